// ===== sv/eidws_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, payload types and control structs of the entity ID allocator.
package eidws_pkg;

  localparam int ENTITY_SLOTS   = 1024;
  localparam int SIGNATURE_BITS = 32;

  // Field widths of the transaction payloads.
  localparam int ID_W  = 10;
  localparam int SIG_W = 32;

  // Free-list position and free count widths follow from the slot count.
  localparam int IDX_W = $clog2(ENTITY_SLOTS);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(ENTITY_SLOTS - 1);

  typedef enum logic [1:0] {
    MODE_CREATE  = 2'd0,
    MODE_DESTROY = 2'd1,
    MODE_SET     = 2'd2,
    MODE_GET     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_RANGE     = 2'd2,
    STAT_NONE_LIVE = 2'd3
  } status_e;

  typedef struct packed {
    mode_e             mode;
    logic [ID_W-1:0]   entity_index;
    logic [SIG_W-1:0]  signature_value;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]   granted_id;
    logic [SIG_W-1:0]  signature_read;
    status_e           status;
    logic [ID_W-1:0]   living_count;
  } out_t;

  // Requests from the control logic to the free list.
  typedef struct packed {
    logic             rd_en;
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] push_id;
  } fl_req_t;

  // Free list status back to the control logic.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [ID_W-1:0]  head_id;
  } fl_stat_t;

  // Requests from the control logic to the signature store.
  typedef struct packed {
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic [SIGNATURE_BITS-1:0] wr_data;
  } sig_req_t;

endpackage

// ===== sv/entity_id_allocator_with_signatures_unit.sv =====
`timescale 1ns / 1ps
// Top level of the entity ID allocator with per-ID signature words.
//
// Requests arrive on the input channel (in_valid_i, in_stall_o, in_data_i);
// each one is a create, destroy, set-signature or get-signature transaction.
// Exactly one result transaction leaves on the output channel (out_valid_o,
// out_stall_i, out_data_o) for every request, in request order.
// A request is accepted in S_IDLE; in that cycle the free-list head and
// the addressed signature word are read from their synchronous memories.
// In S_EXEC, once the output register is free, the result is formed, the
// memories are written back and the result is loaded into the output
// register. No new request is taken until the current one leaves S_EXEC.
// The output register lets a request be accepted while an earlier result is
// still waiting; if the receiver keeps stalling, the request waits
// in S_EXEC and in_stall_o stays high until the register frees up.
// After reset the signature memory is cleared one word per cycle, covering
// all ENTITY_SLOTS (1024) words; in_stall_o is high during that pass. The free
// list needs no pass: untouched positions read as their reset ID.
module entity_id_allocator_with_signatures_unit import eidws_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  in_t  req_q;
  out_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic [IDX_W-1:0] live_q, live_d;

  fl_req_t  fl_req;
  fl_stat_t fl_stat;
  sig_req_t sig_req;
  logic [SIGNATURE_BITS-1:0] sig_rdata;
  logic clearing;

  logic in_accept;
  logic out_free;
  logic finish;
  logic in_range;

  eidws_free_list u_free_list (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fl_req),
    .stat_o (fl_stat)
  );

  eidws_sig_store u_sig_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (sig_req),
    .rd_data_o  (sig_rdata),
    .clearing_o (clearing)
  );

  // A new request is taken only when no request is in flight and the
  // signature memory is no longer being cleared.
  assign in_stall_o = clearing || (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == S_EXEC) && out_free;
  assign in_range   = int'(req_q.entity_index) < ENTITY_SLOTS;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result forming and write-back. Every error leaves the state untouched.
  always_comb begin
    fl_req          = '0;
    sig_req         = '0;
    live_d          = live_q;
    out_d           = '0;
    out_d.status    = STAT_OK;

    fl_req.rd_en    = in_accept;
    fl_req.push_id  = IDX_W'(req_q.entity_index);
    sig_req.rd_en   = in_accept;
    sig_req.rd_addr = IDX_W'(in_data_i.entity_index);
    sig_req.wr_addr = IDX_W'(req_q.entity_index);

    if (finish) begin
      if (req_q.mode == MODE_CREATE) begin
        if (fl_stat.count == '0) begin
          out_d.status = STAT_EMPTY;
        end else begin
          out_d.granted_id = fl_stat.head_id;
          fl_req.pop       = 1'b1;
          live_d           = live_q + 1'b1;
        end
      end else if (!in_range) begin
        out_d.status = STAT_RANGE;
      end else begin
        unique case (req_q.mode)
          MODE_DESTROY: begin
            if (live_q == '0) begin
              out_d.status = STAT_NONE_LIVE;
            end else begin
              sig_req.wr_en   = 1'b1;
              sig_req.wr_data = '0;
              fl_req.push     = 1'b1;
              live_d          = live_q - 1'b1;
            end
          end
          MODE_SET: begin
            sig_req.wr_en   = 1'b1;
            sig_req.wr_data = SIGNATURE_BITS'(req_q.signature_value);
          end
          MODE_GET: begin
            out_d.signature_read = SIG_W'(sig_rdata);
          end
          default: begin
            out_d.status = STAT_OK;
          end
        endcase
      end
      out_d.living_count = ID_W'(live_d);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      live_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      live_q      <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_data_i;
    end
    if (finish) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/eidws_free_list.sv =====
`timescale 1ns / 1ps
// Ring-buffer free list of IDs held in a synchronous memory with a fill mark.
module eidws_free_list import eidws_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fl_req_t  req_i,
  output fl_stat_t stat_o
);

  logic [IDX_W-1:0] mem [ENTITY_SLOTS];

  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  // Positions below fill_q, and the last position, have been written since
  // reset; the rest still hold their reset contents, the position plus one.
  logic [IDX_W-1:0] fill_q, fill_d;

  logic [IDX_W-1:0] rdata_q;
  logic [IDX_W-1:0] rd_pos_q;
  logic             rd_written_q;
  logic [IDX_W-1:0] head_val;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] pos);
    ring_next = (pos == LAST_POS) ? '0 : pos + 1'b1;
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    fill_d  = fill_q;
    if (req_i.pop) begin
      head_d = ring_next(head_q);
    end
    if (req_i.push) begin
      tail_d = ring_next(tail_q);
      if ((tail_q == fill_q) && (fill_q != LAST_POS)) begin
        fill_d = fill_q + 1'b1;
      end
    end
    if (req_i.pop && !req_i.push) begin
      count_d = count_q - 1'b1;
    end else if (req_i.push && !req_i.pop) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= LAST_POS;
      count_q <= CNT_W'(ENTITY_SLOTS - 1);
      fill_q  <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[tail_q] <= req_i.push_id;
    end
    if (req_i.rd_en) begin
      rdata_q      <= mem[head_q];
      rd_pos_q     <= head_q;
      rd_written_q <= (head_q < fill_q) || (head_q == LAST_POS);
    end
  end

  assign head_val = rd_written_q ? rdata_q : rd_pos_q + 1'b1;

  assign stat_o.count   = count_q;
  assign stat_o.head_id = ID_W'(head_val);

endmodule

// ===== sv/eidws_sig_store.sv =====
`timescale 1ns / 1ps
// Per-ID signature memory with a clearing pass after reset.
module eidws_sig_store import eidws_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sig_req_t                  req_i,
  output logic [SIGNATURE_BITS-1:0] rd_data_o,
  output logic                      clearing_o
);

  logic [SIGNATURE_BITS-1:0] mem [ENTITY_SLOTS];
  logic [SIGNATURE_BITS-1:0] rdata_q;

  logic             clr_q, clr_d;
  logic [IDX_W-1:0] clr_addr_q, clr_addr_d;

  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic [SIGNATURE_BITS-1:0] wr_data;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == LAST_POS) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // The clearing pass owns the write port until it is done.
  assign wr_en   = clr_q || req_i.wr_en;
  assign wr_addr = clr_q ? clr_addr_q : req_i.wr_addr;
  assign wr_data = clr_q ? '0 : req_i.wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o  = rdata_q;
  assign clearing_o = clr_q;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the entity ID allocator with per-ID signature words.
module tb_top;
  import eidws_pkg::*;

  // Cycles without any transaction on either channel before the run is
  // declared hung. The limit sits well above the signature-clearing pass
  // that follows reset.
  localparam int QUIET_LIMIT = 4 * ENTITY_SLOTS;
  localparam int REPORT_MAX  = 10;
  localparam int FULL_LIVE   = ENTITY_SLOTS - 1;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  entity_id_allocator_with_signatures_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Shadow copy of the allocator state. The free list is a ring of IDs read
  // at ring_rd and written at ring_wr; ids_free plus ids_live always equals
  // ENTITY_SLOTS-1, because a destroy is only taken while something is live.
  logic [ID_W-1:0]           ring_ids  [ENTITY_SLOTS];
  logic [IDX_W-1:0]          ring_rd;
  logic [IDX_W-1:0]          ring_wr;
  logic [CNT_W-1:0]          ids_free;
  logic [ID_W-1:0]           ids_live;
  logic [SIGNATURE_BITS-1:0] sig_words [ENTITY_SLOTS];

  // Replies predicted for accepted requests, oldest first.
  out_t pending_replies[$];
  // IDs granted and not yet destroyed. Only used to steer the stimulus
  // toward realistic destroy, set and get targets.
  logic [ID_W-1:0] handed_out[$];

  int fault_count   = 0;
  bit sender_calm   = 1'b0;
  bit receiver_calm = 1'b0;

  // Applies one request to the shadow state and returns the reply the block
  // must produce for it. Fields that carry no meaning stay zero, errors too.
  function automatic out_t allocator_reply(input in_t req);
    out_t r;
    r        = '0;
    r.status = STAT_OK;
    if (req.mode == MODE_CREATE) begin
      if (ids_free == '0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.granted_id = ring_ids[ring_rd];
        ring_rd      = (ring_rd == LAST_POS) ? '0 : ring_rd + 1'b1;
        ids_free     = ids_free - 1'b1;
        ids_live     = ids_live + 1'b1;
      end
    end else if (int'(req.entity_index) >= ENTITY_SLOTS) begin
      // The range check comes first for every addressed request. With the
      // index field exactly as wide as the slot count it can never fire.
      r.status = STAT_RANGE;
    end else begin
      case (req.mode)
        MODE_DESTROY: begin
          // Nothing live is checked after the range check. An ID that was
          // never handed out is still queued again.
          if (ids_live == '0) begin
            r.status = STAT_NONE_LIVE;
          end else begin
            sig_words[req.entity_index] = '0;
            ring_ids[ring_wr]           = req.entity_index;
            ring_wr                     = (ring_wr == LAST_POS) ? '0 : ring_wr + 1'b1;
            ids_free                    = ids_free + 1'b1;
            ids_live                    = ids_live - 1'b1;
          end
        end
        MODE_SET: begin
          sig_words[req.entity_index] = req.signature_value[SIGNATURE_BITS-1:0];
        end
        MODE_GET: begin
          r.signature_read = SIG_W'(sig_words[req.entity_index]);
        end
        default: ;
      endcase
    end
    r.living_count = ids_live;
    return r;
  endfunction

  task automatic report_fault(input string what, input logic [63:0] want,
                              input logic [63:0] got);
    if (fault_count < REPORT_MAX) begin
      $display("[%0t] %s: expected %0h, got %0h", $time, what, want, got);
    end
    fault_count++;
  endtask

  // Sends one request transaction and records its predicted reply once the
  // block has accepted it. Valid is only lowered when a gap follows, so it is
  // never dropped and raised again within one time step.
  task automatic issue_request(input mode_e mode, input logic [ID_W-1:0] index,
                               input logic [SIG_W-1:0] value);
    in_t  req;
    out_t reply;
    int   gap;
    int   k;
    req.mode            = mode;
    req.entity_index    = index;
    req.signature_value = value;
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    reply = allocator_reply(req);
    pending_replies.push_back(reply);
    if (mode == MODE_CREATE && reply.status == STAT_OK) begin
      handed_out.push_back(reply.granted_id);
    end
    if (mode == MODE_DESTROY && reply.status == STAT_OK) begin
      for (k = 0; k < handed_out.size(); k++) begin
        if (handed_out[k] == index) begin
          handed_out.delete(k);
          break;
        end
      end
    end
  endtask

  // Destroys mostly target live IDs; set and get often do too, so that reads
  // return words that were actually written. The rest covers the whole field.
  function automatic logic [ID_W-1:0] pick_index(input mode_e mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (handed_out.size() != 0 && roll < ((mode == MODE_DESTROY) ? 80 : 50)) begin
      return handed_out[$urandom_range(0, handed_out.size() - 1)];
    end
    if (roll < 92) return ID_W'($urandom_range(0, (1 << ID_W) - 1));
    return (roll % 2 == 1) ? ID_W'(ENTITY_SLOTS - 1) : '0;
  endfunction

  function automatic logic [SIG_W-1:0] pick_signature();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return SIG_W'($urandom);
    endcase
  endfunction

  task automatic issue_random(input int pct_create, input int pct_destroy,
                              input int pct_set);
    int    roll;
    mode_e mode;
    roll = $urandom_range(0, 99);
    if (roll < pct_create) mode = MODE_CREATE;
    else if (roll < pct_create + pct_destroy) mode = MODE_DESTROY;
    else if (roll < pct_create + pct_destroy + pct_set) mode = MODE_SET;
    else mode = MODE_GET;
    issue_request(mode, pick_index(mode), pick_signature());
  endtask

  // Requests on a fresh block: destroy with nothing live, and signature
  // access at both ends of the ID range, starting from the cleared store.
  task automatic test_idle_edges();
    issue_request(MODE_DESTROY, 10'd5, '0);
    issue_request(MODE_DESTROY, '1, '1);
    issue_request(MODE_GET, '0, '1);
    issue_request(MODE_GET, '1, '0);
    issue_request(MODE_SET, '0, '1);
    issue_request(MODE_SET, '1, 32'hA5A5_5A5A);
    issue_request(MODE_GET, '0, '0);
    issue_request(MODE_GET, '1, '0);
    issue_request(MODE_SET, '1, '0);
    issue_request(MODE_GET, '1, '1);
  endtask

  // Hand out IDs in order, check that destroy clears the signature, queue IDs
  // that were never handed out (zero among them), then destroy with the live
  // count back at zero.
  task automatic test_create_destroy_reuse();
    repeat (3) issue_request(MODE_CREATE, '1, '1);
    issue_request(MODE_SET, 10'd2, 32'hDEAD_BEEF);
    issue_request(MODE_DESTROY, 10'd2, '0);
    issue_request(MODE_GET, 10'd2, '0);
    issue_request(MODE_DESTROY, 10'd1000, '0);
    issue_request(MODE_DESTROY, '0, '0);
    issue_request(MODE_GET, '0, '0);
    issue_request(MODE_DESTROY, 10'd3, '1);
    issue_request(MODE_CREATE, '0, '0);
  endtask

  // Mostly creates until every ID is live, then keeps hammering the empty
  // list for a while. The head position wraps on the way.
  task automatic test_fill_to_exhaustion();
    int extra;
    int guard;
    extra = 0;
    for (guard = 0; guard < 1500 && extra < 30; guard++) begin
      if (ids_live == ID_W'(FULL_LIVE)) extra++;
      issue_random((ids_free == '0) ? 50 : 90, 3, 4);
    end
  endtask

  // Mixed traffic that slowly drains the allocator, so that IDs freed after
  // the fill are reused through the wrapped ring.
  task automatic test_random_churn();
    repeat (650) issue_random(30, 35, 20);
  endtask

  // Receiver: stalls a random number of cycles ahead of each reply, with
  // calm stretches of no stalling, and checks every accepted reply against
  // the oldest prediction.
  initial begin : reply_checker
    int   hold;
    out_t want;
    out_t got;
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
      hold = receiver_calm ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1 || out_stall_i);
      got = out_data_o;
      if (pending_replies.size() == 0) begin
        report_fault("reply with no request pending", '0, 64'(got));
      end else begin
        want = pending_replies.pop_front();
        if (got.granted_id !== want.granted_id) begin
          report_fault("granted_id", 64'(want.granted_id), 64'(got.granted_id));
        end
        if (got.signature_read !== want.signature_read) begin
          report_fault("signature_read", 64'(want.signature_read),
                       64'(got.signature_read));
        end
        if (got.status !== want.status) begin
          report_fault("status", 64'(want.status), 64'(got.status));
        end
        if (got.living_count !== want.living_count) begin
          report_fault("living_count", 64'(want.living_count), 64'(got.living_count));
        end
      end
    end
  end

  // Ends the run if neither channel moves a transaction for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin : test_sequence
    int i;
    // Shadow state after reset: IDs 1 to N-1 queued in order, store cleared.
    for (i = 0; i < ENTITY_SLOTS; i++) begin
      ring_ids[i]  = (i < ENTITY_SLOTS - 1) ? ID_W'(i + 1) : '0;
      sig_words[i] = '0;
    end
    ring_rd  = '0;
    ring_wr  = LAST_POS;
    ids_free = CNT_W'(ENTITY_SLOTS - 1);
    ids_live = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The block holds off requests during its clearing pass; the first
    // request simply waits for in_stall_o to drop.
    test_idle_edges();
    test_create_destroy_reuse();
    test_fill_to_exhaustion();
    test_random_churn();

    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    // Keep the clock running so that any stray extra reply is caught.
    repeat (16) @(posedge clk_i);
    if (fault_count == 0 && pending_replies.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
